// File: hdl/rcenc_pkg.sv
// rcenc_pkg: shared widths, defaults and the queue entry type of the
// rns scaled coefficient encoder; used by every module in hdl
`default_nettype none
package rcenc_pkg;
   localparam int unsigned SCALE_W     = 41;
   localparam int unsigned SLOTCNT_W   = 16;
   localparam int unsigned MODCNT_W    = 3;
   localparam int unsigned MOD_W       = 60;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned SLOT_W      = 15;
   localparam int unsigned MODIDX_W    = 2;
   localparam int unsigned IVAL_W      = 63;
   localparam int unsigned NUM_MOD_REG = 4;
   localparam int unsigned SCALE_SPLIT = 20;
   localparam int unsigned CSR_IDX_W   = 3;

   localparam int unsigned MAX_MODULI_DEF = 4;
   localparam int unsigned MAX_SLOTS_DEF  = 32768;
   localparam int unsigned FRAC_BITS_DEF  = 16;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] REG_SCALE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_SLOTS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOD_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MOD_A        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MOD_B        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MOD_C        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MOD_D        = 3'd6;

   localparam logic [SCALE_W-1:0]   SCALE_RST        = 41'd1073741824;
   localparam logic [SLOTCNT_W-1:0] ACTIVE_SLOTS_RST = 16'd2048;
   localparam logic [MODCNT_W-1:0]  MOD_COUNT_RST    = 3'd1;
   localparam logic [MOD_W-1:0]     MODULUS_RST      = 60'd2;

   typedef struct packed {
      logic [IVAL_W-1:0] ival;
      logic              neg;
      logic [SLOT_W-1:0] slot;
      logic              fin;
      logic              err;
   } q_entry_type;
endpackage
`default_nettype wire

// File: hdl/rcenc_front.sv
// rcenc_front: accepts input values, checks the slot index, multiplies by
// the scale and rounds; depends on rcenc_pkg
`default_nettype none
module rcenc_front #(
   parameter int unsigned MAX_SLOTS = rcenc_pkg::MAX_SLOTS_DEF,
   parameter int unsigned FRAC_BITS = rcenc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [rcenc_pkg::VALUE_W-1:0] req_real_value,
   input  wire logic [rcenc_pkg::SLOT_W-1:0]        req_slot_index,
   input  wire logic                                req_final_value,
   input  wire logic [rcenc_pkg::SCALE_W-1:0]       scale,
   input  wire logic [rcenc_pkg::SLOTCNT_W-1:0]     active_slots,
   output logic                                     push_valid,
   input  wire logic                                push_ready,
   output rcenc_pkg::q_entry_type                   push_data
);
   localparam int unsigned HI_W   = rcenc_pkg::SCALE_W - rcenc_pkg::SCALE_SPLIT;
   localparam int unsigned A_W    = rcenc_pkg::VALUE_W + HI_W;
   localparam int unsigned B_W    = rcenc_pkg::VALUE_W + rcenc_pkg::SCALE_SPLIT;
   localparam int unsigned PROD_W = rcenc_pkg::VALUE_W + rcenc_pkg::SCALE_W;
   localparam int unsigned SUM_W  = PROD_W + 1;
   localparam int unsigned LIM_W  = rcenc_pkg::SLOTCNT_W + 1;
   localparam logic [SUM_W-1:0] ROUND_ADD =
      (FRAC_BITS > 0) ? (SUM_W'(1) << (FRAC_BITS - 1)) : '0;
   localparam logic [LIM_W-1:0] SLOT_LIMIT = LIM_W'(MAX_SLOTS);

   logic                          valid_ff, valid_in;
   logic [A_W-1:0]                a_ff;
   logic [B_W-1:0]                b_ff;
   logic                          neg_ff, fin_ff, err_ff;
   logic [rcenc_pkg::SLOT_W-1:0]  slot_ff;
   logic                          accept;
   logic [rcenc_pkg::VALUE_W-1:0] mag;
   logic [LIM_W-1:0]              limit;
   logic [SUM_W-1:0]              sum;
   logic [SUM_W-1:0]              shifted;
   logic                          over;

   assign req_ready = !valid_ff || push_ready;
   assign accept    = req_valid && req_ready;
   assign mag       = req_real_value[rcenc_pkg::VALUE_W-1] ?
                      rcenc_pkg::VALUE_W'(-req_real_value) : req_real_value;
   assign limit     = ({1'b0, active_slots} < SLOT_LIMIT) ? {1'b0, active_slots} : SLOT_LIMIT;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // split multiply: high and low part of the scale
   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff    <= A_W'(mag) * A_W'(scale[rcenc_pkg::SCALE_W-1:rcenc_pkg::SCALE_SPLIT]);
         b_ff    <= B_W'(mag) * B_W'(scale[rcenc_pkg::SCALE_SPLIT-1:0]);
         neg_ff  <= req_real_value[rcenc_pkg::VALUE_W-1];
         slot_ff <= req_slot_index;
         fin_ff  <= req_final_value;
         err_ff  <= LIM_W'(req_slot_index) >= limit;
      end
   end

   assign sum     = (SUM_W'(a_ff) << rcenc_pkg::SCALE_SPLIT) + SUM_W'(b_ff) + ROUND_ADD;
   assign shifted = sum >> FRAC_BITS;
   assign over    = |shifted[SUM_W-1:rcenc_pkg::IVAL_W];

   assign push_valid     = valid_ff;
   assign push_data.ival = over ? '1 : shifted[rcenc_pkg::IVAL_W-1:0];
   assign push_data.neg  = neg_ff;
   assign push_data.slot = slot_ff;
   assign push_data.fin  = fin_ff;
   assign push_data.err  = err_ff;
endmodule
`default_nettype wire

// File: hdl/rcenc_queue.sv
// rcenc_queue: two-entry queue between front and back end
// depends on rcenc_pkg for the entry type
`default_nettype none
module rcenc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  rcenc_pkg::q_entry_type push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output rcenc_pkg::q_entry_type pop_data
);
   rcenc_pkg::q_entry_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign wr_ptr_in  = wr_ptr_ff ^ do_push;
   assign rd_ptr_in  = rd_ptr_ff ^ do_pop;
   assign count_in   = count_ff + 2'(do_push) - 2'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (push_valid && !push_ready) |=> (count_ff == 2'd2 || do_pop || $past(do_pop)))
      else $error("queue refused a push while not full");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count lost a push");
endmodule
`default_nettype wire

// File: hdl/rcenc_back.sv
// rcenc_back: reduces each queued integer modulo the moduli in use, one
// remainder, one dividend bit per cycle, and drives the result register; uses rcenc_pkg
`default_nettype none
module rcenc_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               pop_valid,
   output logic                                    pop_ready,
   input  rcenc_pkg::q_entry_type                  pop_data,
   input  wire logic [rcenc_pkg::MODCNT_W-1:0]     mod_count,
   input  wire logic [rcenc_pkg::MOD_W-1:0]        moduli [rcenc_pkg::NUM_MOD_REG],
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [rcenc_pkg::MOD_W-1:0]             rsp_residue,
   output logic [rcenc_pkg::MODIDX_W-1:0]          rsp_modulus_index,
   output logic [rcenc_pkg::SLOT_W-1:0]            rsp_coeff_position,
   output logic                                    rsp_run_end,
   output logic                                    rsp_plaintext_end,
   output logic                                    rsp_index_error
);
   localparam int unsigned MW    = rcenc_pkg::MOD_W;
   localparam int unsigned IW    = rcenc_pkg::IVAL_W;
   localparam int unsigned CNT_W = $clog2(IW);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(IW - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   rcenc_pkg::q_entry_type             item_ff, item_in;
   logic [IW-1:0]                      shift_ff, shift_in;
   logic [MW-1:0]                      rem_ff, rem_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [rcenc_pkg::MODIDX_W-1:0]     k_ff, k_in;
   logic                               out_valid_ff, out_valid_in;
   logic [MW-1:0]                      out_res_ff, out_res_in;
   logic [rcenc_pkg::MODIDX_W-1:0]     out_k_ff;
   logic [rcenc_pkg::SLOT_W-1:0]       out_slot_ff;
   logic                               out_end_ff, out_fin_ff, out_err_ff;
   logic                               out_end_in, out_load;
   logic [MW-1:0]                      m;
   logic [MW:0]                        trial;
   logic [MW:0]                        diff;
   logic [MW-1:0]                      residue;
   logic                               last_mod;

   assign m        = moduli[k_ff];
   assign trial    = {rem_ff, shift_ff[IW-1]};
   assign diff     = trial - {1'b0, m};
   assign last_mod = ({1'b0, k_ff} + 3'd1) == mod_count;
   assign residue  = (m <= MW'(1)) ? '0 :
                     (item_ff.neg && rem_ff != '0) ? m - rem_ff : rem_ff;
   assign pop_ready = state_ff == S_IDLE;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      out_load     = 1'b0;
      out_res_in   = residue;
      out_end_in   = last_mod;
      out_valid_in = out_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               item_in  = pop_data;
               shift_in = pop_data.ival;
               rem_in   = '0;
               cnt_in   = '0;
               k_in     = '0;
               state_in = pop_data.err ? S_EMIT : S_DIV;
            end
         end
         S_DIV: begin
            // restoring reduction, one dividend bit per cycle
            rem_in   = trial >= {1'b0, m} ? diff[MW-1:0] : trial[MW-1:0];
            shift_in = shift_ff << 1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (item_ff.err) begin
               out_res_in = '0;
               out_end_in = 1'b1;
            end
            if (!out_valid_ff || rsp_ready) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               if (item_ff.err || last_mod) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + rcenc_pkg::MODIDX_W'(1);
                  shift_in = item_ff.ival;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = S_DIV;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      k_ff     <= k_in;
      if (out_load) begin
         out_res_ff  <= out_res_in;
         out_k_ff    <= k_ff;
         out_slot_ff <= item_ff.slot;
         out_end_ff  <= out_end_in;
         out_fin_ff  <= out_end_in && item_ff.fin;
         out_err_ff  <= item_ff.err;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_residue        = out_res_ff;
   assign rsp_modulus_index  = out_k_ff;
   assign rsp_coeff_position = out_slot_ff;
   assign rsp_run_end        = out_end_ff;
   assign rsp_plaintext_end  = out_fin_ff;
   assign rsp_index_error    = out_err_ff;

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_err_ff) |-> (out_res_ff == '0 && out_k_ff == '0 && out_end_ff))
      else $error("error result with nonzero payload");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_end_ff) |-> !out_fin_ff)
      else $error("plaintext end outside run end");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> item_ff.err == 1'b0)
      else $error("reduction started for an index error");
endmodule
`default_nettype wire

// File: hdl/rns_scaled_coefficient_encoder_unit.sv
// path from input acceptance to the first result: front register, queue and
// back-end load, then per modulus the bit-serial reduction over all 63 bits of
// the queued integer and a load of the result register; result stalls add to this
// the shared reduction unit takes a new item only after it has sent the last
// result of the one before; an index error item skips the reduction and gives one error result
// reset: synchronous; clears the queue, pipeline and result valid, and sets the
// registers to scale 2^30, 2048 active slots, one modulus, every modulus 2
`default_nettype none
module rns_scaled_coefficient_encoder_unit #(
   parameter int unsigned MAX_MODULI = rcenc_pkg::MAX_MODULI_DEF,
   parameter int unsigned MAX_SLOTS  = rcenc_pkg::MAX_SLOTS_DEF,
   parameter int unsigned FRAC_BITS  = rcenc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [rcenc_pkg::VALUE_W-1:0] req_real_value,
   input  wire logic [rcenc_pkg::SLOT_W-1:0]         req_slot_index,
   input  wire logic                                 req_final_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [rcenc_pkg::MOD_W-1:0]               rsp_residue,
   output logic [rcenc_pkg::MODIDX_W-1:0]            rsp_modulus_index,
   output logic [rcenc_pkg::SLOT_W-1:0]              rsp_coeff_position,
   output logic                                      rsp_run_end,
   output logic                                      rsp_plaintext_end,
   output logic                                      rsp_index_error,
   input  wire logic                                 csr_write_enable,
   input  wire logic [rcenc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rcenc_pkg::MOD_W-1:0]          csr_write_data
);
   localparam int unsigned MOD_LIMIT =
      (MAX_MODULI < rcenc_pkg::NUM_MOD_REG) ? MAX_MODULI : rcenc_pkg::NUM_MOD_REG;

   logic [rcenc_pkg::SCALE_W-1:0]   scale_ff;
   logic [rcenc_pkg::SLOTCNT_W-1:0] active_slots_ff;
   logic [rcenc_pkg::MODCNT_W-1:0]  mod_count_ff;
   logic [rcenc_pkg::MOD_W-1:0]     moduli_ff [rcenc_pkg::NUM_MOD_REG];
   logic [rcenc_pkg::MODCNT_W-1:0]  mod_count_eff;
   logic                            f_valid, f_ready, b_valid, b_ready;
   rcenc_pkg::q_entry_type          f_data, b_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff        <= rcenc_pkg::SCALE_RST;
         active_slots_ff <= rcenc_pkg::ACTIVE_SLOTS_RST;
         mod_count_ff    <= rcenc_pkg::MOD_COUNT_RST;
         for (int i = 0; i < rcenc_pkg::NUM_MOD_REG; i++) begin
            moduli_ff[i] <= rcenc_pkg::MODULUS_RST;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            rcenc_pkg::REG_SCALE:      scale_ff <= csr_write_data[rcenc_pkg::SCALE_W-1:0];
            rcenc_pkg::REG_ACTIVE_SLOTS:
               active_slots_ff <= csr_write_data[rcenc_pkg::SLOTCNT_W-1:0];
            rcenc_pkg::REG_MOD_COUNT:
               mod_count_ff <= csr_write_data[rcenc_pkg::MODCNT_W-1:0];
            rcenc_pkg::REG_MOD_A:      moduli_ff[0] <= csr_write_data;
            rcenc_pkg::REG_MOD_B:      moduli_ff[1] <= csr_write_data;
            rcenc_pkg::REG_MOD_C:      moduli_ff[2] <= csr_write_data;
            rcenc_pkg::REG_MOD_D:      moduli_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // zero acts as one, above the limit clamps
   assign mod_count_eff =
      (mod_count_ff == '0) ? rcenc_pkg::MODCNT_W'(1) :
      (mod_count_ff > rcenc_pkg::MODCNT_W'(MOD_LIMIT)) ? rcenc_pkg::MODCNT_W'(MOD_LIMIT) :
      mod_count_ff;

   rcenc_front #(
      .MAX_SLOTS (MAX_SLOTS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_real_value (req_real_value),
      .req_slot_index (req_slot_index),
      .req_final_value(req_final_value),
      .scale          (scale_ff),
      .active_slots   (active_slots_ff),
      .push_valid     (f_valid),
      .push_ready     (f_ready),
      .push_data      (f_data)
   );

   rcenc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_data (f_data),
      .pop_valid (b_valid),
      .pop_ready (b_ready),
      .pop_data  (b_data)
   );

   rcenc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (b_valid),
      .pop_ready         (b_ready),
      .pop_data          (b_data),
      .mod_count         (mod_count_eff),
      .moduli            (moduli_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_residue       (rsp_residue),
      .rsp_modulus_index (rsp_modulus_index),
      .rsp_coeff_position(rsp_coeff_position),
      .rsp_run_end       (rsp_run_end),
      .rsp_plaintext_end (rsp_plaintext_end),
      .rsp_index_error   (rsp_index_error)
   );
endmodule
`default_nettype wire

// File: test/tb_rns_scaled_coefficient_encoder_unit.sv
// tb_rns_scaled_coefficient_encoder_unit: self-checking bench for the rns coefficient encoder;
// predicts every residue from its own copy of the registers, drives bursts, stalls results
// depends on hdl/rcenc_pkg.sv and hdl/rns_scaled_coefficient_encoder_unit.sv
`default_nettype none
module tb_rns_scaled_coefficient_encoder_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import rcenc_pkg::*;

   localparam int unsigned IDLE_LIMIT = 5000;
   localparam int unsigned SETTLE     = 300;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [SLOT_W-1:0]         slot;
      logic                      fin;
   } coeff_item_type;

   typedef struct {
      logic [MOD_W-1:0]    residue;
      logic [MODIDX_W-1:0] mod_idx;
      logic [SLOT_W-1:0]   position;
      logic                run_end;
      logic                pt_end;
      logic                idx_err;
   } residue_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [VALUE_W-1:0] req_real_value = '0;
   logic [SLOT_W-1:0] req_slot_index = '0;
   logic req_final_value = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [MOD_W-1:0] rsp_residue;
   logic [MODIDX_W-1:0] rsp_modulus_index;
   logic [SLOT_W-1:0] rsp_coeff_position;
   logic rsp_run_end, rsp_plaintext_end, rsp_index_error;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MOD_W-1:0] csr_write_data = '0;

   // shadow registers
   logic [SCALE_W-1:0]   sh_scale = SCALE_RST;
   logic [SLOTCNT_W-1:0] sh_active_slots = ACTIVE_SLOTS_RST;
   logic [MODCNT_W-1:0]  sh_mod_count = MOD_COUNT_RST;
   logic [MOD_W-1:0]     sh_moduli [NUM_MOD_REG];

   coeff_item_type pending_coeffs[$];
   residue_type    expected_residues[$];
   int unsigned error_count = 0;
   int unsigned coeffs_sent = 0;
   int unsigned residues_checked = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   int unsigned stall_tick = 0;

   rns_scaled_coefficient_encoder_unit u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < NUM_MOD_REG; i++) sh_moduli[i] = MODULUS_RST;
   end

   function automatic void predict_residues(coeff_item_type it);
      logic [31:0]  mag;
      logic [127:0] prod;
      logic [63:0]  ival, m, r;
      logic         neg;
      int unsigned  limit, cnt;
      residue_type  e;
      limit = (sh_active_slots < MAX_SLOTS_DEF) ? sh_active_slots : MAX_SLOTS_DEF;
      if (it.slot >= limit) begin
         e = '{residue: '0, mod_idx: '0, position: it.slot, run_end: 1'b1,
               pt_end: it.fin, idx_err: 1'b1};
         expected_residues.push_back(e);
         return;
      end
      cnt = sh_mod_count;
      if (cnt < 1) cnt = 1;
      if (cnt > 4) cnt = 4;
      if (cnt > MAX_MODULI_DEF) cnt = MAX_MODULI_DEF;
      neg = it.value[31];
      mag = neg ? (~it.value + 32'd1) : it.value;
      // exact product plus half an lsb, then drop the fraction
      prod = 128'(mag) * 128'(sh_scale) + (128'd1 << (FRAC_BITS_DEF - 1));
      prod = prod >> FRAC_BITS_DEF;
      ival = (prod > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : prod[63:0];
      for (int k = 0; k < cnt; k++) begin
         m = 64'(sh_moduli[k]);
         r = '0;
         if (m > 1) begin
            r = ival % m;
            if (neg && r != 0) r = m - r;
         end
         e = '{residue: r[MOD_W-1:0], mod_idx: k[MODIDX_W-1:0], position: it.slot,
               run_end: (k == cnt - 1), pt_end: (k == cnt - 1) ? it.fin : 1'b0,
               idx_err: 1'b0};
         expected_residues.push_back(e);
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("MISMATCH %s: got %0h expected %0h (residue #%0d)", what, got, want,
               residues_checked);
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_coeffs.size() != 0) begin
            coeff_item_type it;
            it = pending_coeffs.pop_front();
            req_real_value <= it.value;
            req_slot_index <= it.slot;
            req_final_value <= it.fin;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern periodically reloaded with a random value, sometimes no stalls at all
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick % 64 == 0)
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
         rsp_ready <= stall_pattern[stall_tick % 16];
      end
   end

   // checker, prediction on acceptance, and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_residues.size() == 0) begin
               report_mismatch("unexpected result transaction", 64'(rsp_residue), 64'd0);
            end else begin
               residue_type e;
               e = expected_residues.pop_front();
               if (rsp_residue !== e.residue)
                  report_mismatch("residue", 64'(rsp_residue), 64'(e.residue));
               if (rsp_modulus_index !== e.mod_idx)
                  report_mismatch("modulus_index", 64'(rsp_modulus_index), 64'(e.mod_idx));
               if (rsp_coeff_position !== e.position)
                  report_mismatch("coeff_position", 64'(rsp_coeff_position),
                                  64'(e.position));
               if (rsp_run_end !== e.run_end)
                  report_mismatch("run_end", 64'(rsp_run_end), 64'(e.run_end));
               if (rsp_plaintext_end !== e.pt_end)
                  report_mismatch("plaintext_end", 64'(rsp_plaintext_end), 64'(e.pt_end));
               if (rsp_index_error !== e.idx_err)
                  report_mismatch("index_error", 64'(rsp_index_error), 64'(e.idx_err));
            end
            residues_checked++;
         end
         if (req_valid && req_ready) begin
            coeff_item_type it;
            it.value = req_real_value;
            it.slot = req_slot_index;
            it.fin = req_final_value;
            predict_residues(it);
            coeffs_sent++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [MOD_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         REG_SCALE:        sh_scale = data[SCALE_W-1:0];
         REG_ACTIVE_SLOTS: sh_active_slots = data[SLOTCNT_W-1:0];
         REG_MOD_COUNT:    sh_mod_count = data[MODCNT_W-1:0];
         REG_MOD_A:        sh_moduli[0] = data;
         REG_MOD_B:        sh_moduli[1] = data;
         REG_MOD_C:        sh_moduli[2] = data;
         REG_MOD_D:        sh_moduli[3] = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain;
      do @(negedge clock);
      while (pending_coeffs.size() != 0 || req_valid || expected_residues.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic queue_coeff(logic signed [VALUE_W-1:0] v, logic [SLOT_W-1:0] s,
                              logic f);
      coeff_item_type it;
      it.value = v;
      it.slot = s;
      it.fin = f;
      pending_coeffs.push_back(it);
   endtask

   function automatic logic [MOD_W-1:0] random_modulus();
      logic [MOD_W-1:0] m;
      case ($urandom_range(0, 4))
         0: m = 60'($urandom_range(0, 40));
         1: m = 60'($urandom);
         2: m = {28'h0, 32'($urandom)} << $urandom_range(0, 28);
         default: m = {28'($urandom), 32'($urandom)};
      endcase
      return m;
   endfunction

   task automatic queue_random(int n);
      int unsigned limit;
      logic signed [VALUE_W-1:0] v;
      logic [SLOT_W-1:0] s;
      limit = (sh_active_slots < MAX_SLOTS_DEF) ? sh_active_slots : MAX_SLOTS_DEF;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: v = $signed(32'($urandom_range(0, 65535)) - 32'd32768);
            1: v = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: v = $signed({16'($urandom), 16'h8000});
            default: v = $signed(32'($urandom));
         endcase
         if (limit > 0 && $urandom_range(0, 7) != 0)
            s = 15'($urandom_range(0, limit - 1));
         else
            s = 15'($urandom);
         queue_coeff(v, s, ($urandom_range(0, 7) == 0));
      end
   endtask

   task automatic set_moduli(logic [MOD_W-1:0] a, logic [MOD_W-1:0] b,
                             logic [MOD_W-1:0] c, logic [MOD_W-1:0] d);
      write_reg(REG_MOD_A, a);
      write_reg(REG_MOD_B, b);
      write_reg(REG_MOD_C, c);
      write_reg(REG_MOD_D, d);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset registers: one modulus of 2, 2048 slots
      queue_coeff(32'sh0001_0000, 15'd0, 1'b0);
      queue_coeff(-32'sh0001_0000, 15'd2047, 1'b0);
      queue_coeff(32'sh0000_0000, 15'd2048, 1'b1);
      queue_coeff(32'sh7FFF_FFFF, 15'h7FFF, 1'b1);
      drain();

      // scale of one: halves round away from zero, extreme moduli
      write_reg(REG_SCALE, 60'd1);
      write_reg(REG_ACTIVE_SLOTS, 60'd32768);
      write_reg(REG_MOD_COUNT, 60'd4);
      set_moduli(60'd0, 60'd1, 60'd7, 60'hFFF_FFFF_FFFF_FFFF);
      queue_coeff(32'sh0000_8000, 15'd1, 1'b0);
      queue_coeff(-32'sh0000_8000, 15'd2, 1'b0);
      queue_coeff(32'sh0000_7FFF, 15'd3, 1'b0);
      queue_coeff(-32'sh0001_8000, 15'd4, 1'b0);
      queue_coeff(32'sh0007_0000, 15'd5, 1'b0);
      queue_coeff(-32'sh0007_0000, 15'd6, 1'b1);
      queue_coeff(32'sh8000_0000, 15'h7FFF, 1'b1);
      queue_coeff(32'sh7FFF_FFFF, 15'h5555, 1'b0);
      queue_coeff(32'sh0000_0000, 15'h2AAA, 1'b1);
      drain();

      // scale of 2^40, count above the limit clamps to four
      write_reg(REG_SCALE, 60'h100_0000_0000);
      write_reg(REG_MOD_COUNT, 60'd7);
      set_moduli(60'hFFF_FFFF_FFFF_FFFF, 60'd2, 60'hFFF_FFFF_FFFF_FFC5, 60'd3);
      queue_coeff(32'sh8000_0000, 15'd0, 1'b0);
      queue_coeff(32'sh7FFF_FFFF, 15'h7FFF, 1'b1);
      queue_coeff(-32'sh0000_0001, 15'd9, 1'b0);
      queue_coeff(32'sh0000_0001, 15'd10, 1'b1);
      drain();

      // count zero acts as one, no active slots rejects everything
      write_reg(REG_MOD_COUNT, 60'd0);
      write_reg(REG_ACTIVE_SLOTS, 60'd0);
      queue_coeff(32'sh1234_5678, 15'd0, 1'b1);
      queue_random(15);
      drain();

      // random phases over several register settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_reg(REG_ACTIVE_SLOTS, 60'd1);
            1: write_reg(REG_ACTIVE_SLOTS, 60'd32768);
            2: write_reg(REG_ACTIVE_SLOTS, 60'hFFFF);
            default: write_reg(REG_ACTIVE_SLOTS, 60'($urandom_range(1, 32768)));
         endcase
         write_reg(REG_SCALE, (ph == 1) ? 60'h100_0000_0000 :
                              60'({9'($urandom), 32'($urandom)} >> $urandom_range(0, 40)));
         write_reg(REG_MOD_COUNT, 60'($urandom_range(1, 4)));
         set_moduli(random_modulus(), random_modulus(), random_modulus(), random_modulus());
         queue_random(65);
         drain();
      end

      $display("coefficients sent %0d, residues checked %0d, over moduli counts 0..7,",
               coeffs_sent, residues_checked);
      $display("scales 1..2^40 and active slot settings 0..65535");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
